// ===== hdl/fzc_pkg.sv =====
package fzc_pkg;

  localparam int GRADE_BITS_DEFAULT = 12;

  // quotient shift width of the shared divider, also the duty width
  localparam int QW = 16;
  localparam int CW = 4;

  localparam logic signed [11:0] TARGET_RESET = 12'sd400;
  localparam logic [11:0] SPAN_RESET = 12'd80;
  localparam logic [15:0] FULL_RESET = 16'd1024;
  localparam logic signed [15:0] FAULT_LIMIT = -16'sd1600;

  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_SPAN = 2'd1;
  localparam logic [1:0] REG_FULL = 2'd2;

  typedef struct packed {
    logic load_sample;
    logic load_err;
    logic div_load_e;
    logic div_load_d;
    logic div_load_f;
    logic div_step;
    logic store_qe;
    logic store_qd;
    logic load_rules;
    logic load_num;
    logic load_out;
  } fzc_cmd_t;

  typedef struct packed {
    logic fault;
  } fzc_status_t;

endpackage

// ===== hdl/fzc_div.sv =====
module fzc_div #(
  parameter int DW = 15
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic                    step,
  input  logic [DW-1:0]           rem_init,
  input  logic [fzc_pkg::QW-1:0]  q_init,
  input  logic [DW-1:0]           divisor,
  output logic [fzc_pkg::QW-1:0]  quotient
);
  import fzc_pkg::*;

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [QW-1:0] qsh;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // restoring division, one quotient bit per step
  assign shifted = {rem, qsh[QW-1]};
  assign ge = shifted >= {1'b0, dvs};
  assign diff = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= rem_init;
      qsh <= q_init;
      dvs <= divisor;
    end else if (step) begin
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      qsh <= {qsh[QW-2:0], ge};
    end
  end

  assign quotient = qsh;

endmodule

// ===== hdl/fzc_datapath.sv =====
module fzc_datapath #(
  parameter int GRADE_BITS = fzc_pkg::GRADE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fzc_pkg::fzc_cmd_t     cmd,
  output fzc_pkg::fzc_status_t  status,
  input  logic [15:0]           sample_temperature,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  output logic [15:0]           duty,
  output logic                  no_rule_fired
);
  import fzc_pkg::*;

  localparam int GW = GRADE_BITS + 1;
  localparam int DW = (GRADE_BITS + 3 > 12) ? GRADE_BITS + 3 : 12;
  localparam int NW = GRADE_BITS + 18;
  localparam logic [GW-1:0] ONE = {1'b1, {GRADE_BITS{1'b0}}};

  logic signed [11:0] target;
  logic [11:0]        span;
  logic [15:0]        full;
  logic signed [17:0] prev_err;
  logic signed [15:0] sample;
  logic signed [17:0] err;
  logic signed [17:0] delta;
  logic [GW-1:0]      qe;
  logic [GW-1:0]      qd;
  logic [GW-1:0]      high;
  logic [GW-1:0]      mid;
  logic [GW-1:0]      low;
  logic [NW-1:0]      num;
  logic [GRADE_BITS+2:0] sum2;
  logic               nrf;

  logic signed [17:0] err_c;
  logic signed [17:0] delta_c;
  logic [11:0]        span_eff;
  logic [17:0]        abs_e;
  logic [17:0]        abs_d;
  logic               sat_e;
  logic               sat_d;
  logic [GW-1:0]      neg_e, neg_d, pos_e, pos_d, zer_e, zer_d;
  logic [GRADE_BITS+1:0] wsum;
  logic [GRADE_BITS+1:0] sum;
  logic [DW-1:0]      div_rem_init;
  logic [QW-1:0]      div_q_init;
  logic [DW-1:0]      div_divisor;
  logic [QW-1:0]      quotient;

  assign status.fault = $signed(sample_temperature) < FAULT_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TARGET_RESET;
      span <= SPAN_RESET;
      full <= FULL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET: target <= cfg_data[11:0];
        REG_SPAN:   span <= cfg_data[11:0];
        REG_FULL:   full <= cfg_data;
        default: ;
      endcase
    end
  end

  assign err_c = {{6{target[11]}}, target} - {{2{sample[15]}}, sample};
  assign delta_c = err_c - prev_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
    end else if (cmd.load_err) begin
      prev_err <= err_c;
    end
  end

  assign span_eff = (span == 12'd0) ? 12'd1 : span;
  assign abs_e = err[17] ? 18'(-err) : err;
  assign abs_d = delta[17] ? 18'(-delta) : delta;
  assign sat_e = abs_e >= {6'd0, span_eff};
  assign sat_d = abs_d >= {6'd0, span_eff};

  // memberships from the clipped magnitude ratio
  assign neg_e = err[17] ? qe : '0;
  assign pos_e = (!err[17] && err != 18'sd0) ? qe : '0;
  assign zer_e = ONE - qe;
  assign neg_d = delta[17] ? qd : '0;
  assign pos_d = (!delta[17] && delta != 18'sd0) ? qd : '0;
  assign zer_d = ONE - qd;

  // 2*high + mid never exceeds 2*ONE
  assign wsum = {high, 1'b0} + {1'b0, mid};
  assign sum = {1'b0, high} + {1'b0, mid} + {1'b0, low};

  always_comb begin
    if (cmd.div_load_f) begin
      div_rem_init = DW'(num[NW-1:QW]);
      div_q_init = num[QW-1:0];
      div_divisor = DW'(sum2);
    end else begin
      div_rem_init = cmd.div_load_d ? DW'(abs_d[11:0]) : DW'(abs_e[11:0]);
      div_q_init = '0;
      div_divisor = DW'(span_eff);
    end
  end

  fzc_div #(.DW(DW)) u_div (
    .clk      (clk),
    .load     (cmd.div_load_e | cmd.div_load_d | cmd.div_load_f),
    .step     (cmd.div_step),
    .rem_init (div_rem_init),
    .q_init   (div_q_init),
    .divisor  (div_divisor),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_sample) sample <= sample_temperature;
    if (cmd.load_err) begin
      err <= err_c;
      delta <= delta_c;
    end
    if (cmd.store_qe) qe <= sat_e ? ONE : {1'b0, quotient[GRADE_BITS-1:0]};
    if (cmd.store_qd) qd <= sat_d ? ONE : {1'b0, quotient[GRADE_BITS-1:0]};
    if (cmd.load_rules) begin
      high <= (neg_e < neg_d) ? neg_e : neg_d;
      mid <= (zer_e < zer_d) ? zer_e : zer_d;
      low <= (pos_e < pos_d) ? pos_e : pos_d;
    end
    if (cmd.load_num) begin
      num <= NW'(wsum) * NW'(full);
      sum2 <= {sum, 1'b0};
      nrf <= sum == '0;
    end
    if (cmd.load_out) begin
      duty <= nrf ? '0 : quotient;
      no_rule_fired <= nrf;
    end
  end

endmodule

// ===== hdl/fzc_ctrl.sv =====
module fzc_ctrl #(
  parameter int GRADE_BITS = fzc_pkg::GRADE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  fzc_pkg::fzc_status_t  status,
  output fzc_pkg::fzc_cmd_t     cmd
);
  import fzc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_LDE   = 4'd2;
  localparam logic [3:0] S_RUNE  = 4'd3;
  localparam logic [3:0] S_LDD   = 4'd4;
  localparam logic [3:0] S_RUND  = 4'd5;
  localparam logic [3:0] S_GRADE = 4'd6;
  localparam logic [3:0] S_RULES = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_LDF   = 4'd9;
  localparam logic [3:0] S_RUNF  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  localparam logic [CW-1:0] LAST_G = CW'(GRADE_BITS - 1);
  localparam logic [CW-1:0] LAST_F = CW'(QW - 1);

  logic [3:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !status.fault) begin
          cmd.load_sample = 1'b1;
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        cmd.load_err = 1'b1;
        state_next = S_LDE;
      end
      S_LDE: begin
        cmd.div_load_e = 1'b1;
        cnt_next = '0;
        state_next = S_RUNE;
      end
      S_RUNE: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_G) state_next = S_LDD;
      end
      S_LDD: begin
        cmd.store_qe = 1'b1;
        cmd.div_load_d = 1'b1;
        cnt_next = '0;
        state_next = S_RUND;
      end
      S_RUND: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_G) state_next = S_GRADE;
      end
      S_GRADE: begin
        cmd.store_qd = 1'b1;
        state_next = S_RULES;
      end
      S_RULES: begin
        cmd.load_rules = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.load_num = 1'b1;
        state_next = S_LDF;
      end
      S_LDF: begin
        cmd.div_load_f = 1'b1;
        cnt_next = '0;
        state_next = S_RUNF;
      end
      S_RUNF: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_F) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/fuzzy_temperature_controller.sv =====
// Requests are handled one at a time: in_stall stays high from acceptance until the duty is
// registered, while the shared radix-2 divider runs two grade divisions of GRADE_BITS steps
// and one of 16 for the duty; a stalled output holds the result and blocks the next request.
// Sensor-fault requests (signed sample below FAULT_LIMIT, -1600) are accepted and give no result.
// Synchronous reset: config registers go to their defaults, previous error clears to 0,
// no result pending.
module fuzzy_temperature_controller #(
  parameter int GRADE_BITS = fzc_pkg::GRADE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] sample_temperature,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] duty,
  output logic        no_rule_fired,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import fzc_pkg::*;

  fzc_cmd_t    cmd;
  fzc_status_t status;

  assign cfg_ready = 1'b1;

  fzc_ctrl #(.GRADE_BITS(GRADE_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  fzc_datapath #(.GRADE_BITS(GRADE_BITS)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .sample_temperature (sample_temperature),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .duty               (duty),
    .no_rule_fired      (no_rule_fired)
  );

endmodule
